// File: design/cceb_pkg.sv
package cceb_pkg;

  // Map geometry.
  localparam int GRID_MAX  = 32;
  localparam int LAYER_MAX = 16;
  localparam int MAP_DEPTH = GRID_MAX * GRID_MAX * LAYER_MAX;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);

  // Field widths.
  localparam int POS_W  = 24;
  localparam int EN_W   = 32;
  localparam int SUM_W  = 48;
  localparam int IDX_W  = 14;
  localparam int CS_W   = 20;
  localparam int GC_W   = 6;
  localparam int DM_W   = 2;
  localparam int LT_W   = 7;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Divider geometry: signed dividend, magnitude one bit narrower.
  localparam int DIVD_W = POS_W + 1;
  localparam int MAG_W  = DIVD_W - 1;
  localparam int DIVS_W = CS_W;
  localparam int QUO_W  = MAG_W + 1;
  localparam int CNT_W  = $clog2(MAG_W + 1);

  // Index arithmetic widths.
  localparam int IX_W   = QUO_W + 1;
  localparam int T1_W   = IX_W + GC_W + 1;
  localparam int T2_W   = T1_W + 1;
  localparam int NLOG_W = LT_W;
  localparam int T3_W   = T2_W + NLOG_W + 1;
  localparam int FLAT_W = T3_W + 1;
  localparam int GG_W   = 2 * GC_W;
  localparam int SIZE_W = GG_W + NLOG_W;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [1:0] {
    OP_SIGNAL = 2'd0,
    OP_ABSORB = 2'd1,
    OP_READ   = 2'd2,
    OP_END    = 2'd3
  } opcode_e;

  localparam logic [2:0] REG_CELL_SIZE  = 3'd0;
  localparam logic [2:0] REG_GRID_CELLS = 3'd1;
  localparam logic [2:0] REG_DEPTH_MODE = 3'd2;
  localparam logic [2:0] REG_SPLIT      = 3'd3;
  localparam logic [2:0] REG_PITCH      = 3'd4;
  localparam logic [2:0] REG_LAYERS     = 3'd5;
  localparam logic [2:0] REG_GROUP      = 3'd6;

  localparam logic [DM_W-1:0] MODE_SPLIT   = 2'd1;
  localparam logic [DM_W-1:0] MODE_GROUPED = 2'd2;

  typedef struct packed {
    logic              start;
    logic              floor_mode;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [EN_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W + 1)'(b);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

// File: design/cceb_in_if.sv
interface cceb_in_if import cceb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [EN_W-1:0]         energy;
  logic [IDX_W-1:0]        read_index;

  modport source (output valid, opcode, pos_x, pos_y, pos_z, energy, read_index,
                  input ready);
  modport sink (input valid, opcode, pos_x, pos_y, pos_z, energy, read_index,
                output ready);
endinterface

// File: design/cceb_out_if.sv
interface cceb_out_if import cceb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] cell_index;
  logic             in_map;
  logic [SUM_W-1:0] cell_energy;
  logic [SUM_W-1:0] sampling_total;
  logic [SUM_W-1:0] absorber_total;

  modport source (output valid, cell_index, in_map, cell_energy, sampling_total,
                  absorber_total, input ready);
  modport sink (input valid, cell_index, in_map, cell_energy, sampling_total,
                absorber_total, output ready);
endinterface

// File: design/cceb_ram.sv
module cceb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/cceb_div.sv
module cceb_div import cceb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  // Restoring division, one quotient bit per cycle. The magnitude shifts out
  // at the top of quo_q while quotient bits shift in at the bottom.
  logic [MAG_W-1:0]  quo_q, quo_d;
  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVS_W-1:0] dvs_q, dvs_d;
  logic              neg_q, neg_d;
  logic              floor_q, floor_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              ge;
  logic [DIVD_W-1:0] absval;
  logic [QUO_W-1:0]  qext;

  always_comb begin
    trial   = {rem_q, quo_q[MAG_W-1]};
    diff    = trial - {1'b0, dvs_q};
    ge      = trial >= {1'b0, dvs_q};
    absval  = req_i.dividend[DIVD_W-1] ? (~req_i.dividend + 1'b1) : req_i.dividend;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    floor_d = floor_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start && !busy_q) begin
      quo_d   = absval[MAG_W-1:0];
      rem_d   = '0;
      dvs_d   = req_i.divisor;
      neg_d   = req_i.dividend[DIVD_W-1];
      floor_d = req_i.floor_mode;
      cnt_d   = CNT_W'(MAG_W - 1);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      quo_d = {quo_q[MAG_W-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
    neg_q   <= neg_d;
    floor_q <= floor_d;
  end

  // A negative floored quotient with a remainder rounds one further down,
  // which is plain one's complement of the magnitude.
  always_comb begin
    qext = {1'b0, quo_q};
    if (!neg_q) begin
      rsp_o.quot = qext;
    end else if (floor_q && (rem_q != '0)) begin
      rsp_o.quot = ~qext;
    end else begin
      rsp_o.quot = ~qext + 1'b1;
    end
    rsp_o.busy = busy_q;
    rsp_o.done = done_q;
  end

endmodule

// File: design/calorimeter_cell_energy_binner_unit.sv
// Flow: a signal deposit runs floor divisions in the shared bit-serial divider,
//   with depth and truncating grouping divisions in grouped layer mode, then the
//   index arithmetic and a map read-modify-write; a read only reads the map.
// Throughput: one word at a time; the next word waits until a result is posted.
//   An end of event adds a clearing pass over all 16384 cells of the map.
// Reset: asynchronous, active low; it clears the totals and starts the same
//   clearing pass, during which no word is accepted (register writes are).
module calorimeter_cell_energy_binner_unit import cceb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  cceb_in_if.sink           in_i,
  cceb_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // The sequencer walks a signal word through the divider, the index arithmetic and
  // a read-modify-write of one map cell. The result sits in an output register,
  // so a new word may be taken while the previous result still waits.
  typedef enum logic [14:0] {
    S_CLEAR = 15'h0001,
    S_IDLE  = 15'h0002,
    S_DIVX  = 15'h0004,
    S_DIVY  = 15'h0008,
    S_DIVZ  = 15'h0010,
    S_DIVG  = 15'h0020,
    S_DIVN  = 15'h0040,
    S_MUL1  = 15'h0080,
    S_MUL2  = 15'h0100,
    S_MUL3  = 15'h0200,
    S_FLAT  = 15'h0400,
    S_CHK   = 15'h0800,
    S_RD    = 15'h1000,
    S_RDW   = 15'h2000,
    S_OUT   = 15'h4000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [CS_W-1:0]         cs_q;
  logic [GC_W-1:0]         g_q;
  logic [DM_W-1:0]         dm_q;
  logic signed [POS_W-1:0] sp_q;
  logic [CS_W-1:0]         lp_q;
  logic [LT_W-1:0]         lt_q;
  logic [LT_W-1:0]         lpg_q;
  logic                    cfg_wr;

  // Captured word.
  opcode_e                 op_q, op_d;
  logic signed [POS_W-1:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic [EN_W-1:0]         en_q, en_d;
  logic [IDX_W-1:0]        ri_q, ri_d;

  // Index arithmetic.
  logic signed [IX_W-1:0]   ix_q, ix_d, iy_q, iy_d, iz_q, iz_d;
  logic [NLOG_W-1:0]        nlog_q, nlog_d;
  logic signed [T1_W-1:0]   t1_q, t1_d;
  logic signed [T2_W-1:0]   t2_q, t2_d;
  logic signed [T3_W-1:0]   t3_q, t3_d;
  logic signed [FLAT_W-1:0] flat_q, flat_d;
  logic [GG_W-1:0]          gg_q, gg_d;
  logic [SIZE_W-1:0]        size_q, size_d;
  logic                     hit_q, hit_d;
  logic [SUM_W-1:0]         celle_q, celle_d;

  // Totals and clearing pass.
  logic [SUM_W-1:0]  samp_q, samp_d, abs_q, abs_d;
  logic [MAP_AW-1:0] clr_q, clr_d;

  // Output register.
  logic              ovld_q, ovld_d;
  logic [IDX_W-1:0]  o_idx_q, o_idx_d;
  logic              o_hit_q, o_hit_d;
  logic [SUM_W-1:0]  o_cell_q, o_cell_d, o_samp_q, o_samp_d, o_abs_q, o_abs_d;

  // Divider and map memory.
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic              ram_we;
  logic [MAP_AW-1:0] ram_waddr, ram_raddr;
  logic [SUM_W-1:0]  ram_wdata, ram_rdata, new_sum;

  // Zero divisors act as one.
  logic [CS_W-1:0]   cs_eff, lp_eff;
  logic [LT_W-1:0]   lpg_eff;
  logic              grouped, in_div, hit;

  assign cs_eff  = (cs_q == '0) ? CS_W'(1) : cs_q;
  assign lp_eff  = (lp_q == '0) ? CS_W'(1) : lp_q;
  assign lpg_eff = (lpg_q == '0) ? LT_W'(1) : lpg_q;
  assign grouped = (dm_q == MODE_GROUPED) && (lpg_eff < lt_q);

  // Configuration port: writes complete in the access phase, no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q  <= CS_W'(1000);
      g_q   <= GC_W'(32);
      dm_q  <= '0;
      sp_q  <= '0;
      lp_q  <= CS_W'(1000);
      lt_q  <= LT_W'(16);
      lpg_q <= LT_W'(1);
    end else if (cfg_wr) begin
      case (paddr[ADDR_W-1:2])
        REG_CELL_SIZE:  cs_q  <= pwdata[CS_W-1:0];
        REG_GRID_CELLS: g_q   <= pwdata[GC_W-1:0];
        REG_DEPTH_MODE: dm_q  <= pwdata[DM_W-1:0];
        REG_SPLIT:      sp_q  <= pwdata[POS_W-1:0];
        REG_PITCH:      lp_q  <= pwdata[CS_W-1:0];
        REG_LAYERS:     lt_q  <= pwdata[LT_W-1:0];
        REG_GROUP:      lpg_q <= pwdata[LT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_CELL_SIZE:  prdata = DATA_W'(cs_q);
      REG_GRID_CELLS: prdata = DATA_W'(g_q);
      REG_DEPTH_MODE: prdata = DATA_W'(dm_q);
      REG_SPLIT:      prdata = DATA_W'($unsigned(sp_q));
      REG_PITCH:      prdata = DATA_W'(lp_q);
      REG_LAYERS:     prdata = DATA_W'(lt_q);
      REG_GROUP:      prdata = DATA_W'(lpg_q);
      default:        prdata = '0;
    endcase
  end

  // Divider operands per state. The two transverse and the depth divisions
  // floor; the grouping divisions truncate toward zero.
  assign in_div = (state_q == S_DIVX) || (state_q == S_DIVY) || (state_q == S_DIVZ) ||
                  (state_q == S_DIVG) || (state_q == S_DIVN);

  always_comb begin
    div_req.start      = in_div && !div_rsp.busy && !div_rsp.done;
    div_req.floor_mode = 1'b1;
    div_req.dividend   = {px_q[POS_W-1], px_q};
    div_req.divisor    = cs_eff;
    case (state_q)
      S_DIVY: div_req.dividend = {py_q[POS_W-1], py_q};
      S_DIVZ: begin
        div_req.dividend = {pz_q[POS_W-1], pz_q};
        div_req.divisor  = lp_eff;
      end
      S_DIVG: begin
        div_req.floor_mode = 1'b0;
        div_req.dividend   = iz_q[DIVD_W-1:0];
        div_req.divisor    = DIVS_W'(lpg_eff);
      end
      S_DIVN: begin
        div_req.floor_mode = 1'b0;
        div_req.dividend   = DIVD_W'(lt_q);
        div_req.divisor    = DIVS_W'(lpg_eff);
      end
      default: begin
      end
    endcase
  end

  cceb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // The flat index only counts when it is nonnegative and below both the
  // configured map size and the physical capacity.
  assign hit = !flat_q[FLAT_W-1] && (flat_q < $signed({1'b0, size_q})) &&
               (flat_q < MAP_DEPTH);

  assign new_sum   = sat_add(ram_rdata, en_q);
  assign ram_raddr = (state_q == S_CHK) ? flat_q[MAP_AW-1:0] : MAP_AW'(ri_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = flat_q[MAP_AW-1:0];
    ram_wdata = new_sum;
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if ((state_q == S_RDW) && (op_q == OP_SIGNAL)) begin
      ram_we = 1'b1;
    end
  end

  cceb_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    px_d     = px_q;
    py_d     = py_q;
    pz_d     = pz_q;
    en_d     = en_q;
    ri_d     = ri_q;
    ix_d     = ix_q;
    iy_d     = iy_q;
    iz_d     = iz_q;
    nlog_d   = nlog_q;
    t1_d     = t1_q;
    t2_d     = t2_q;
    t3_d     = t3_q;
    flat_d   = flat_q;
    gg_d     = gg_q;
    size_d   = size_q;
    hit_d    = hit_q;
    celle_d  = celle_q;
    samp_d   = samp_q;
    abs_d    = abs_q;
    clr_d    = clr_q;
    ovld_d   = ovld_q && !out_o.ready;
    o_idx_d  = o_idx_q;
    o_hit_d  = o_hit_q;
    o_cell_d = o_cell_q;
    o_samp_d = o_samp_q;
    o_abs_d  = o_abs_q;

    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == MAP_AW'(MAP_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          op_d    = opcode_e'(in_i.opcode);
          px_d    = in_i.pos_x;
          py_d    = in_i.pos_y;
          pz_d    = in_i.pos_z;
          en_d    = in_i.energy;
          ri_d    = in_i.read_index;
          hit_d   = 1'b0;
          celle_d = '0;
          case (opcode_e'(in_i.opcode))
            OP_SIGNAL: state_d = S_DIVX;
            OP_READ:   state_d = S_RD;
            default:   state_d = S_OUT;
          endcase
        end
      end
      S_DIVX: begin
        if (div_rsp.done) begin
          ix_d    = $signed(div_rsp.quot) + $signed({1'b0, g_q[GC_W-1:1]});
          state_d = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_rsp.done) begin
          iy_d = $signed(div_rsp.quot) + $signed({1'b0, g_q[GC_W-1:1]});
          if (grouped) begin
            state_d = S_DIVZ;
          end else begin
            state_d = S_MUL1;
            if (dm_q == MODE_SPLIT) begin
              iz_d   = (pz_q > sp_q) ? IX_W'(1) : '0;
              nlog_d = NLOG_W'(2);
            end else begin
              iz_d   = '0;
              nlog_d = NLOG_W'(1);
            end
          end
        end
      end
      S_DIVZ: begin
        if (div_rsp.done) begin
          iz_d    = $signed(div_rsp.quot) + $signed({1'b0, lt_q[LT_W-1:1]});
          state_d = S_DIVG;
        end
      end
      S_DIVG: begin
        if (div_rsp.done) begin
          iz_d    = $signed(div_rsp.quot);
          state_d = S_DIVN;
        end
      end
      S_DIVN: begin
        if (div_rsp.done) begin
          nlog_d  = div_rsp.quot[NLOG_W-1:0];
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        t1_d    = ix_q * $signed({1'b0, g_q});
        gg_d    = g_q * g_q;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        t2_d    = t1_q + iy_q;
        state_d = S_MUL3;
      end
      S_MUL3: begin
        t3_d    = t2_q * $signed({1'b0, nlog_q});
        size_d  = gg_q * nlog_q;
        state_d = S_FLAT;
      end
      S_FLAT: begin
        flat_d  = t3_q + iz_q;
        state_d = S_CHK;
      end
      S_CHK: begin
        hit_d   = hit;
        state_d = hit ? S_RDW : S_OUT;
      end
      S_RD: begin
        state_d = S_RDW;
      end
      S_RDW: begin
        if (op_q == OP_SIGNAL) begin
          celle_d = new_sum;
        end else begin
          celle_d = (32'(ri_q) < MAP_DEPTH) ? ram_rdata : '0;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        // Wait until the output register is free, then post the result and
        // fold the word into the totals.
        if (!ovld_q || out_o.ready) begin
          ovld_d   = 1'b1;
          o_idx_d  = hit_q ? flat_q[IDX_W-1:0] : '0;
          o_hit_d  = hit_q;
          o_cell_d = celle_q;
          o_samp_d = samp_q;
          o_abs_d  = abs_q;
          state_d  = S_IDLE;
          case (op_q)
            OP_SIGNAL: begin
              samp_d   = sat_add(samp_q, en_q);
              o_samp_d = samp_d;
            end
            OP_ABSORB: begin
              abs_d   = sat_add(abs_q, en_q);
              o_abs_d = abs_d;
            end
            OP_END: begin
              samp_d  = '0;
              abs_d   = '0;
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      samp_q  <= '0;
      abs_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      samp_q  <= samp_d;
      abs_q   <= abs_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    px_q     <= px_d;
    py_q     <= py_d;
    pz_q     <= pz_d;
    en_q     <= en_d;
    ri_q     <= ri_d;
    ix_q     <= ix_d;
    iy_q     <= iy_d;
    iz_q     <= iz_d;
    nlog_q   <= nlog_d;
    t1_q     <= t1_d;
    t2_q     <= t2_d;
    t3_q     <= t3_d;
    flat_q   <= flat_d;
    gg_q     <= gg_d;
    size_q   <= size_d;
    hit_q    <= hit_d;
    celle_q  <= celle_d;
    o_idx_q  <= o_idx_d;
    o_hit_q  <= o_hit_d;
    o_cell_q <= o_cell_d;
    o_samp_q <= o_samp_d;
    o_abs_q  <= o_abs_d;
  end

  assign out_o.valid          = ovld_q;
  assign out_o.cell_index     = o_idx_q;
  assign out_o.in_map         = o_hit_q;
  assign out_o.cell_energy    = o_cell_q;
  assign out_o.sampling_total = o_samp_q;
  assign out_o.absorber_total = o_abs_q;

  // No word may enter while the map is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_i.ready)
    else $error("word accepted during clearing pass");

  // A clearing pass always runs with the totals already at zero.
  a_totals_zero_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> ((samp_q == '0) && (abs_q == '0)))
    else $error("totals not cleared with the map");

  // Map data is used only the cycle after its read address was issued.
  a_read_before_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDW) |-> ($past(state_q) == S_CHK || $past(state_q) == S_RD))
    else $error("map data used without a preceding read");

  // A result outside the map reports cell index zero.
  a_miss_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && !o_hit_q) |-> (o_idx_q == '0))
    else $error("nonzero cell index on a miss");

endmodule
